>>> design/assert_macros.svh
// Assertion macros for the design files.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define SRSW_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("srsw: same-cycle check failed");

// Next-cycle implication, gated off during reset.
`define SRSW_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("srsw: next-cycle check failed");

`endif

>>> design/srsw_pkg.sv
// Shared constants, types and helpers for the selective-repeat sender window.
// No dependencies.
package srsw_pkg;

    localparam int FRAME_LIMIT  = 256;
    localparam int WINDOW_LIMIT = 8;

    localparam int FRAME_W   = $clog2(FRAME_LIMIT);   // frame number / bitmap address
    localparam int WIN_W     = $clog2(WINDOW_LIMIT);  // offset inside window
    localparam int WIN_CNT_W = WIN_W + 1;             // window size, 1..WINDOW_LIMIT
    localparam int TOTAL_W   = 9;
    localparam int WREG_W    = 4;
    localparam int CNT_W     = 9;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CNT_W-1:0]   CNT_MAX          = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET      = TOTAL_W'(10);
    localparam logic [WREG_W-1:0]  WINDOW_RESET     = WREG_W'(4);

    typedef enum logic
    {
        REG_TOTAL_FRAMES,
        REG_WINDOW_WIDTH
    } cfg_reg_t;

    typedef enum logic [3:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_ACK_RD,
        ST_ACK_CHK,
        ST_SLIDE_RD,
        ST_SLIDE_CHK,
        ST_ACK_OUT
    } state_t;

    // Bitmap write request.
    typedef struct packed
    {
        logic               en;
        logic [FRAME_W-1:0] addr;
        logic               data;
    } bm_wr_t;

    // Bitmap read request.
    typedef struct packed
    {
        logic               en;
        logic [FRAME_W-1:0] addr;
    } bm_rd_t;

    function automatic logic [TOTAL_W-1:0] eff_total(input logic [TOTAL_W-1:0] t);
        logic [TOTAL_W-1:0] r;
        r = (t > TOTAL_W'(FRAME_LIMIT)) ? TOTAL_W'(FRAME_LIMIT) : t;
        return r;
    endfunction

    function automatic logic [WIN_CNT_W-1:0] eff_window(input logic [WREG_W-1:0] w);
        logic [WIN_CNT_W-1:0] r;
        if (w == '0)
            r = WIN_CNT_W'(1);
        else if (32'(w) > WINDOW_LIMIT)
            r = WIN_CNT_W'(WINDOW_LIMIT);
        else
            r = WIN_CNT_W'(w);
        return r;
    endfunction

endpackage

>>> design/srsw_bitmap_ram.sv
// Acknowledged-frame bitmap: one write port, one read port, registered read.
// Depends on srsw_pkg.
module srsw_bitmap_ram
(
    input  logic            clk,
    input  srsw_pkg::bm_wr_t wr,
    input  srsw_pkg::bm_rd_t rd,
    output logic            rd_data
);

    logic mem [srsw_pkg::FRAME_LIMIT];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/selective_repeat_sender_window_core.sv
// Selective-repeat ARQ sender window; reset is async, active low. After reset the bitmap
// is swept to zero, one entry a cycle, over all 256 entries with in_stall high (config writes taken).
// Send round: accept, then scan (one bitmap read per window slot below the total), then one
// result per open frame, one a cycle unless out_stall holds it, or one status result if none
// is open. Ack: read and check the ack's bit, then slide the base past acked frames; one item at a time; the next is
// taken once the last result is loaded. Depends on srsw_pkg, srsw_bitmap_ram, macros.
`include "assert_macros.svh"

module selective_repeat_sender_window_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [srsw_pkg::PADDR_W-1:0]          paddr,
    input  logic [srsw_pkg::PDATA_W-1:0]          pwdata,
    output logic [srsw_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready,

    // input items
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  mode,
    input  logic [7:0]                            ack_number,

    // result items
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [7:0]                            frame_number,
    output logic                                  frame_valid,
    output logic                                  last_of_run,
    output logic [8:0]                            base_now,
    output logic [8:0]                            acked_total,
    output logic                                  all_done,
    output logic                                  ack_accepted
);

    localparam int FW = srsw_pkg::FRAME_W;
    localparam int WW = srsw_pkg::WIN_W;
    localparam int WC = srsw_pkg::WIN_CNT_W;
    localparam int TW = srsw_pkg::TOTAL_W;
    localparam int CW = srsw_pkg::CNT_W;
    localparam int NW = srsw_pkg::WINDOW_LIMIT;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TW-1:0]                  total_reg;
    logic [srsw_pkg::WREG_W-1:0]    window_reg;
    srsw_pkg::cfg_reg_t             cfg_sel;

    assign cfg_sel = srsw_pkg::cfg_reg_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= srsw_pkg::TOTAL_RESET;
            window_reg <= srsw_pkg::WINDOW_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_sel)
                srsw_pkg::REG_TOTAL_FRAMES: total_reg  <= pwdata[TW-1:0];
                srsw_pkg::REG_WINDOW_WIDTH: window_reg <= pwdata[srsw_pkg::WREG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            srsw_pkg::REG_TOTAL_FRAMES: prdata = srsw_pkg::PDATA_W'(total_reg);
            srsw_pkg::REG_WINDOW_WIDTH: prdata = srsw_pkg::PDATA_W'(window_reg);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control and window state
    // ------------------------------------------------------------------
    srsw_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     base_reg, base_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [7:0]        ack_reg, ack_next;
    logic [WC-1:0]     k_reg, k_next;          // scan offset, 0..window
    logic              rd_pend_reg, rd_pend_next;
    logic [WW-1:0]     rd_idx_reg, rd_idx_next;
    logic [NW-1:0]     mask_reg, mask_next;    // unacked frames found by the scan
    logic              accepted_reg, accepted_next;
    logic [FW-1:0]     clr_reg, clr_next;

    // result register
    logic              out_valid_reg;
    logic [7:0]        frame_number_reg;
    logic              frame_valid_reg;
    logic              last_reg;
    logic [8:0]        base_now_reg;
    logic [8:0]        acked_total_reg;
    logic              all_done_reg;
    logic              ack_accepted_reg;

    // result load request
    logic              ld;
    logic [7:0]        ld_frame;
    logic              ld_fvalid;
    logic              ld_last;
    logic              ld_accepted;

    // bitmap port
    srsw_pkg::bm_wr_t  bm_wr;
    srsw_pkg::bm_rd_t  bm_rd;
    logic              bm_rd_data;

    srsw_bitmap_ram u_bitmap
    (
        .clk     (clk),
        .wr      (bm_wr),
        .rd      (bm_rd),
        .rd_data (bm_rd_data)
    );

    // ------------------------------------------------------------------
    // Shared combinational terms
    // ------------------------------------------------------------------
    logic [TW-1:0]  tot;
    logic [WC-1:0]  win;
    logic [CW:0]    scan_addr;
    logic           issue_ok;
    logic [CW:0]    win_end;
    logic           ack_in_win;
    logic           slide_ok;
    logic           out_free;
    logic [WW-1:0]  low_idx;
    logic [NW-1:0]  mask_rest;
    logic           accept_in;

    assign tot       = srsw_pkg::eff_total(total_reg);
    assign win       = srsw_pkg::eff_window(window_reg);
    assign scan_addr = {1'b0, base_reg} + (CW + 1)'(k_reg);
    assign issue_ok  = (k_reg < win) && (scan_addr < (CW + 1)'(tot));
    assign win_end   = {1'b0, base_reg} + (CW + 1)'(win);
    // ack must sit below the total and inside [base, base + window)
    assign ack_in_win = (CW'(ack_reg) < CW'(tot)) && (CW'(ack_reg) >= base_reg)
                        && ((CW + 1)'(ack_reg) < win_end);
    assign slide_ok  = base_reg < CW'(tot);
    assign out_free  = !out_valid_reg || !out_stall;
    assign mask_rest = mask_reg & (mask_reg - NW'(1));
    assign in_stall  = (state_reg != srsw_pkg::ST_IDLE);
    assign accept_in = in_valid && !in_stall;

    // lowest pending offset in the scan mask
    always_comb
    begin
        low_idx = '0;
        for (int i = NW - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                low_idx = WW'(i);
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srsw_pkg::ST_CLEAR:
            begin
                if (clr_reg == FW'(srsw_pkg::FRAME_LIMIT - 1))
                    state_next = srsw_pkg::ST_IDLE;
            end
            srsw_pkg::ST_IDLE:
            begin
                if (accept_in)
                    state_next = mode ? srsw_pkg::ST_ACK_RD : srsw_pkg::ST_SCAN;
            end
            srsw_pkg::ST_SCAN:
            begin
                if (!issue_ok && !rd_pend_reg)
                    state_next = srsw_pkg::ST_EMIT;
            end
            srsw_pkg::ST_EMIT:
            begin
                if (out_free && (mask_rest == '0))
                    state_next = srsw_pkg::ST_IDLE;
            end
            srsw_pkg::ST_ACK_RD:    state_next = srsw_pkg::ST_ACK_CHK;
            srsw_pkg::ST_ACK_CHK:   state_next = srsw_pkg::ST_SLIDE_RD;
            srsw_pkg::ST_SLIDE_RD:
            begin
                state_next = slide_ok ? srsw_pkg::ST_SLIDE_CHK : srsw_pkg::ST_ACK_OUT;
            end
            srsw_pkg::ST_SLIDE_CHK:
            begin
                state_next = bm_rd_data ? srsw_pkg::ST_SLIDE_RD : srsw_pkg::ST_ACK_OUT;
            end
            srsw_pkg::ST_ACK_OUT:
            begin
                if (out_free)
                    state_next = srsw_pkg::ST_IDLE;
            end
            default:                state_next = srsw_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath, bitmap access and result loading
    // ------------------------------------------------------------------
    always_comb
    begin
        base_next     = base_reg;
        count_next    = count_reg;
        ack_next      = ack_reg;
        k_next        = k_reg;
        rd_pend_next  = rd_pend_reg;
        rd_idx_next   = rd_idx_reg;
        mask_next     = mask_reg;
        accepted_next = accepted_reg;
        clr_next      = clr_reg;
        bm_wr         = '0;
        bm_rd         = '0;
        ld            = 1'b0;
        ld_frame      = '0;
        ld_fvalid     = 1'b0;
        ld_last       = 1'b1;
        ld_accepted   = 1'b0;

        case (state_reg)
            srsw_pkg::ST_CLEAR:
            begin
                bm_wr.en   = 1'b1;
                bm_wr.addr = clr_reg;
                bm_wr.data = 1'b0;
                clr_next   = clr_reg + FW'(1);
            end
            srsw_pkg::ST_IDLE:
            begin
                if (accept_in)
                begin
                    ack_next      = ack_number;
                    k_next        = '0;
                    mask_next     = '0;
                    rd_pend_next  = 1'b0;
                    accepted_next = 1'b0;
                end
            end
            srsw_pkg::ST_SCAN:
            begin
                // one read issued a cycle; its data lands in the next cycle
                rd_pend_next = issue_ok;
                if (issue_ok)
                begin
                    bm_rd.en    = 1'b1;
                    bm_rd.addr  = scan_addr[FW-1:0];
                    k_next      = k_reg + WC'(1);
                    rd_idx_next = k_reg[WW-1:0];
                end
                if (rd_pend_reg)
                    mask_next[rd_idx_reg] = !bm_rd_data;
            end
            srsw_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    ld        = 1'b1;
                    ld_fvalid = (mask_reg != '0);
                    ld_frame  = (mask_reg != '0) ? (base_reg[7:0] + 8'(low_idx)) : 8'd0;
                    ld_last   = (mask_rest == '0);
                    mask_next = mask_rest;
                end
            end
            srsw_pkg::ST_ACK_RD:
            begin
                bm_rd.en   = 1'b1;
                bm_rd.addr = ack_reg;
            end
            srsw_pkg::ST_ACK_CHK:
            begin
                if (ack_in_win && !bm_rd_data)
                begin
                    bm_wr.en      = 1'b1;
                    bm_wr.addr    = ack_reg;
                    bm_wr.data    = 1'b1;
                    accepted_next = 1'b1;
                    if (count_reg != srsw_pkg::CNT_MAX)
                        count_next = count_reg + CW'(1);
                end
            end
            srsw_pkg::ST_SLIDE_RD:
            begin
                // write from the check cycle has landed; no forwarding needed
                if (slide_ok)
                begin
                    bm_rd.en   = 1'b1;
                    bm_rd.addr = base_reg[FW-1:0];
                end
            end
            srsw_pkg::ST_SLIDE_CHK:
            begin
                if (bm_rd_data)
                    base_next = base_reg + CW'(1);
            end
            srsw_pkg::ST_ACK_OUT:
            begin
                if (out_free)
                begin
                    ld          = 1'b1;
                    ld_accepted = accepted_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= srsw_pkg::ST_CLEAR;
            base_reg     <= '0;
            count_reg    <= '0;
            k_reg        <= '0;
            rd_pend_reg  <= 1'b0;
            accepted_reg <= 1'b0;
            clr_reg      <= '0;
            mask_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            count_reg    <= count_next;
            k_reg        <= k_next;
            rd_pend_reg  <= rd_pend_next;
            accepted_reg <= accepted_next;
            clr_reg      <= clr_next;
            mask_reg     <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ack_reg    <= ack_next;
        rd_idx_reg <= rd_idx_next;
    end

    // ------------------------------------------------------------------
    // Result register: status fields sampled at load time
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            frame_number_reg <= ld_frame;
            frame_valid_reg  <= ld_fvalid;
            last_reg         <= ld_last;
            base_now_reg     <= base_reg;
            acked_total_reg  <= count_reg;
            all_done_reg     <= (count_reg >= CW'(tot));
            ack_accepted_reg <= ld_accepted;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_number = frame_number_reg;
    assign frame_valid  = frame_valid_reg;
    assign last_of_run  = last_reg;
    assign base_now     = base_now_reg;
    assign acked_total  = acked_total_reg;
    assign all_done     = all_done_reg;
    assign ack_accepted = ack_accepted_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // the base only moves forward
    `SRSW_ASSERT_NEXT(a_base_forward, clk, rst_n, 1'b1, base_reg >= $past(base_reg))

    // an emitted frame lies below the transfer length
    `SRSW_ASSERT_IMPL(a_frame_in_total, clk, rst_n, out_valid && frame_valid,
                      CW'(frame_number) < CW'(tot))

    // the scan never marks frames beyond the window
    `SRSW_ASSERT_IMPL(a_mask_in_window, clk, rst_n, state_reg == srsw_pkg::ST_EMIT,
                      (mask_reg >> win) == '0)

    // an accepted ack is counted exactly once (or the count is saturated)
    `SRSW_ASSERT_NEXT(a_ack_counted, clk, rst_n,
                      (state_reg == srsw_pkg::ST_ACK_CHK) && bm_wr.en,
                      (count_reg == $past(count_reg) + CW'(1))
                      || ($past(count_reg) == srsw_pkg::CNT_MAX))

endmodule

>>> verif/selective_repeat_sender_window_core_test.sv
// Testbench for selective_repeat_sender_window_core: drives send rounds and acks,
// predicts every result from a local model of the window and checks them in order.
// Depends on srsw_pkg and the core RTL.
`timescale 1ns / 100ps

module selective_repeat_sender_window_core_test;

    // Watchdog limit on cycles with no accepted item, result or register write.
    // Covers the bitmap clear after reset and long random stall runs.
    localparam int QUIET_LIMIT = 4000;

    typedef enum logic
    {
        SEND_ROUND,
        ACK_IN
    } item_mode_t;

    typedef struct packed
    {
        item_mode_t  mode;
        logic [7:0]  ack;
    } arq_item_t;

    typedef struct packed
    {
        logic [7:0]  frame;
        logic        valid;
        logic        last;
        logic [8:0]  base;
        logic [8:0]  acked;
        logic        done;
        logic        accepted;
    } window_result_t;

    // DUT ports; every input starts at a known value.
    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           psel         = 1'b0;
    logic                           penable      = 1'b0;
    logic                           pwrite       = 1'b0;
    logic [srsw_pkg::PADDR_W-1:0]   paddr        = '0;
    logic [srsw_pkg::PDATA_W-1:0]   pwdata       = '0;
    logic [srsw_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;
    logic                           in_valid     = 1'b0;
    logic                           in_stall;
    logic                           mode         = 1'b0;
    logic [7:0]                     ack_number   = '0;
    logic                           out_valid;
    logic                           out_stall    = 1'b0;
    logic [7:0]                     frame_number;
    logic                           frame_valid;
    logic                           last_of_run;
    logic [8:0]                     base_now;
    logic [8:0]                     acked_total;
    logic                           all_done;
    logic                           ack_accepted;

    // Items waiting to be driven, and results still owed by the block.
    arq_item_t            pending_items[$];
    window_result_t       expected_results[$];
    window_result_t       want_result;

    // Local copy of the sender window state and its two registers.
    bit                   acked_map[srsw_pkg::FRAME_LIMIT];
    int unsigned          win_base;
    int unsigned          acked_sum;
    logic [8:0]           total_reg;
    logic [3:0]           width_reg;

    int                   send_idle_pct = 13;
    int                   recv_idle_pct = 85;
    int                   mismatches    = 0;
    int                   quiet_cycles  = 0;

    selective_repeat_sender_window_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .ack_number   (ack_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_number (frame_number),
        .frame_valid  (frame_valid),
        .last_of_run  (last_of_run),
        .base_now     (base_now),
        .acked_total  (acked_total),
        .all_done     (all_done),
        .ack_accepted (ack_accepted)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Frame count in force: anything above the bitmap size is clamped.
    function automatic int unsigned frames_in_use();
        return (total_reg > srsw_pkg::FRAME_LIMIT) ? srsw_pkg::FRAME_LIMIT : int'(total_reg);
    endfunction

    // Window in force: zero means one, anything above the limit is clamped.
    function automatic int unsigned window_in_use();
        if (width_reg == 0)
            return 1;
        return (width_reg > srsw_pkg::WINDOW_LIMIT) ? srsw_pkg::WINDOW_LIMIT : int'(width_reg);
    endfunction

    // Advances the window model by one accepted item and queues its results.
    // A send round lists every open frame of the window in ascending order,
    // or one status result if none is open. An ack always gives one status.
    task automatic predict_window_step(logic m, logic [7:0] a);
        window_result_t r;
        int unsigned    lim;
        int unsigned    span;
        int unsigned    i;
        int unsigned    n;
        int unsigned    k;
        lim  = frames_in_use();
        span = window_in_use();
        n    = 0;
        k    = 0;
        r    = '0;
        if (m == ACK_IN)
        begin
            // Must be inside the window, inside the transfer and not a duplicate.
            if (a < lim && a >= win_base && a < win_base + span && !acked_map[a])
            begin
                acked_map[a] = 1'b1;
                if (acked_sum < 511)
                    acked_sum++;
                r.accepted = 1'b1;
            end
            // Slide the base past every acknowledged frame.
            while (win_base < lim && acked_map[win_base])
                win_base++;
        end
        r.base  = 9'(win_base);
        r.acked = 9'(acked_sum);
        r.done  = (acked_sum >= lim);
        if (m == SEND_ROUND)
        begin
            for (i = win_base; i < win_base + span && i < lim; i++)
                if (!acked_map[i])
                    n++;
            for (i = win_base; i < win_base + span && i < lim; i++)
            begin
                if (!acked_map[i])
                begin
                    k++;
                    r.frame = 8'(i);
                    r.valid = 1'b1;
                    r.last  = (k == n);
                    expected_results.push_back(r);
                end
            end
        end
        if (n == 0)
        begin
            r.frame = '0;
            r.valid = 1'b0;
            r.last  = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task automatic queue_item(item_mode_t m, logic [7:0] a);
        arq_item_t it;
        it.mode = m;
        it.ack  = a;
        pending_items.push_back(it);
    endtask

    // Waits until every item is taken and every result has come back,
    // plus a short margin, so the block is idle for a register write.
    task automatic settle();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands when pready is seen.
    task automatic write_register(srsw_pkg::cfg_reg_t idx, int unsigned value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= srsw_pkg::PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == srsw_pkg::REG_TOTAL_FRAMES)
            total_reg = value[8:0];
        else
            width_reg = value[3:0];
    endtask

    // Driver: presents the head of pending_items and holds it until taken.
    // The prediction is made at the edge where the block accepts the item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_window_step(mode, ack_number);
                void'(pending_items.pop_front());
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid   <= 1'b1;
                    mode       <= pending_items[0].mode;
                    ack_number <= pending_items[0].ack;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, and an in-order check of each result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result arrived with nothing expected");
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    check_field("frame_number", 32'(frame_number), 32'(want_result.frame));
                    check_field("frame_valid", 32'(frame_valid), 32'(want_result.valid));
                    check_field("last_of_run", 32'(last_of_run), 32'(want_result.last));
                    check_field("base_now", 32'(base_now), 32'(want_result.base));
                    check_field("acked_total", 32'(acked_total), 32'(want_result.acked));
                    check_field("all_done", 32'(all_done), 32'(want_result.done));
                    check_field("ack_accepted", 32'(ack_accepted),
                                32'(want_result.accepted));
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: a long stretch with no traffic at all means the block hung
    // or owes results that never come.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no traffic for %0d cycles", QUIET_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Stimulus: directed corner cases, then a chain of short transfers that
    // walks the window base all the way to the end of the bitmap.
    initial
    begin : stimulus
        int unsigned frame_pick[$];
        int unsigned seg_total;
        int unsigned f;
        int unsigned tmp;
        int          j;
        int          r;

        total_reg = srsw_pkg::TOTAL_RESET;
        width_reg = srsw_pkg::WINDOW_RESET;
        win_base  = 0;
        acked_sum = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: 10 frames, window of 4.
        queue_item(SEND_ROUND, 8'h00);
        queue_item(ACK_IN, 8'd255);     // beyond the transfer
        queue_item(ACK_IN, 8'd2);       // inside window, base does not move
        queue_item(ACK_IN, 8'd2);       // duplicate
        queue_item(ACK_IN, 8'd0);       // base slides to 1
        queue_item(ACK_IN, 8'd5);       // past the window edge
        queue_item(SEND_ROUND, 8'hFF);  // ack field ignored here
        queue_item(ACK_IN, 8'd1);
        queue_item(ACK_IN, 8'd3);
        queue_item(ACK_IN, 8'd4);

        // Zero window acts as a window of one.
        settle();
        write_register(srsw_pkg::REG_WINDOW_WIDTH, 0);
        queue_item(SEND_ROUND, 8'h00);
        queue_item(ACK_IN, 8'd6);

        // Oversized window and total are clamped: a full round of 8 frames.
        settle();
        write_register(srsw_pkg::REG_WINDOW_WIDTH, 15);
        write_register(srsw_pkg::REG_TOTAL_FRAMES, 511);
        queue_item(SEND_ROUND, 8'h55);
        queue_item(ACK_IN, 8'd12);

        // Empty transfer: empty rounds, every ack rejected.
        settle();
        write_register(srsw_pkg::REG_TOTAL_FRAMES, 0);
        queue_item(SEND_ROUND, 8'h00);
        queue_item(ACK_IN, 8'd5);

        // Total cut below the base: the base stays put.
        settle();
        write_register(srsw_pkg::REG_TOTAL_FRAMES, 3);
        queue_item(SEND_ROUND, 8'hAA);
        queue_item(ACK_IN, 8'd0);

        settle();
        write_register(srsw_pkg::REG_WINDOW_WIDTH, 1);
        write_register(srsw_pkg::REG_TOTAL_FRAMES, 1);
        queue_item(SEND_ROUND, 8'h00);

        // Chained transfers: each one extends the total a little past the base.
        while (win_base < srsw_pkg::FRAME_LIMIT)
        begin
            settle();
            if (win_base < 90)
            begin
                send_idle_pct = 13;
                recv_idle_pct = 85;
            end
            else if (win_base < 175)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 13;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Now and then shrink the total under the base for a couple of items.
            if (win_base > 0 && $urandom_range(4) == 0)
            begin
                write_register(srsw_pkg::REG_TOTAL_FRAMES, $urandom_range(win_base, 0));
                queue_item(SEND_ROUND, 8'($urandom));
                queue_item(ACK_IN, 8'($urandom));
                settle();
            end

            seg_total = win_base + $urandom_range(24, 4);
            if (seg_total >= srsw_pkg::FRAME_LIMIT)
                seg_total = ($urandom_range(1) == 0) ? srsw_pkg::FRAME_LIMIT
                                                     : $urandom_range(511, 257);
            write_register(srsw_pkg::REG_TOTAL_FRAMES, seg_total);
            case ($urandom_range(5))
                0:       write_register(srsw_pkg::REG_WINDOW_WIDTH, 0);
                1:       write_register(srsw_pkg::REG_WINDOW_WIDTH, 1);
                2:       write_register(srsw_pkg::REG_WINDOW_WIDTH, srsw_pkg::WINDOW_LIMIT);
                3:       write_register(srsw_pkg::REG_WINDOW_WIDTH, 15);
                default: write_register(srsw_pkg::REG_WINDOW_WIDTH, $urandom_range(15));
            endcase

            // Rounds: send, ack most of what went out in shuffled order,
            // sometimes repeat an ack, sometimes throw in a random item.
            while (1)
            begin
                while (pending_items.size() != 0)
                    @(negedge clk);
                if (win_base >= frames_in_use())
                    break;
                queue_item(SEND_ROUND, 8'($urandom));
                frame_pick.delete();
                for (f = win_base; f < win_base + window_in_use() && f < frames_in_use(); f++)
                    if (!acked_map[f] && $urandom_range(99) < 80)
                        frame_pick.push_back(f);
                for (j = frame_pick.size() - 1; j > 0; j--)
                begin
                    r             = $urandom_range(j);
                    tmp           = frame_pick[j];
                    frame_pick[j] = frame_pick[r];
                    frame_pick[r] = tmp;
                end
                foreach (frame_pick[k])
                    queue_item(ACK_IN, 8'(frame_pick[k]));
                if (frame_pick.size() != 0 && $urandom_range(9) == 0)
                    queue_item(ACK_IN, 8'(frame_pick[0]));
                if ($urandom_range(99) < 15)
                    queue_item(item_mode_t'($urandom_range(1)), 8'($urandom));
            end
        end

        // Drain, give the block time to show any stray result, then judge.
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
